>>> rtl/rau_pkg.sv
// rational arithmetic unit package: mode and status codes, default word width
// no dependencies
`default_nettype none
package rau_pkg;
  localparam int WordBitsDef = 32;
  localparam int NumBits = 32;
  localparam int DenBits = 31;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;
endpackage
`default_nettype wire

>>> rtl/rau_divider.sv
// rational arithmetic unit: shared restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module rau_divider #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic busy;
  logic [W:0] trial;
  logic [W:0] shifted;

  always_comb begin
    shifted = {rem, quot[W-1]};
    trial = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quot <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CW'(W);
      end else if (busy) begin
        if (trial[W]) begin
          rem <= shifted[W-1:0];
          quot <= {quot[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          quot <= {quot[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with zero count");
endmodule
`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
// rational arithmetic unit top level: sequencer, cross products, gcd via shared divider
// depends on rau_pkg and rau_divider
//
// One item at a time. An item passes through the product and check states, then
// takes one divider pass per Euclid step of the gcd and two more passes to
// reduce numerator and denominator; compare mode needs two passes for the
// thousandths quotients. The shared 64-bit one-bit-per-cycle divider sets the
// running time of an item. s_tready is low from acceptance until the result
// is taken.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WordBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // mode[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98], zero pad
  input  wire logic [135:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // res_num[31:0], res_den[62:32], less[63], approx_equal[64], status[66:65], pad
  output logic [71:0]      m_tdata
);
  import rau_pkg::*;

  localparam int DW = 64;

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_P2, S_P3, S_SUM, S_CHK, S_GCD, S_GWAIT,
    S_RN, S_RNW, S_RD, S_RDW, S_QA, S_QAW, S_QBW, S_OUT
  } state_t;

  state_t state;
  logic [2:0] mode;
  logic signed [NumBits-1:0] an, bn;
  logic [DenBits-1:0] ad, bd;
  logic signed [NumBits:0] mul_a, mul_b;
  logic signed [2*NumBits+1:0] prod_w;
  logic signed [DW-1:0] prod;
  logic signed [DW-1:0] p, q, rd, rn;
  logic [DW-1:0] gy, g, nm;
  logic bad;
  logic qa_neg;
  logic [DW-1:0] qa_mag;
  logic signed [NumBits-1:0] o_num;
  logic [DenBits-1:0] o_den;
  logic o_less, o_apx;
  status_t o_st;

  logic dv_start, dv_done;
  logic [DW-1:0] dv_a, dv_b, dv_q, dv_r;

  rau_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  function automatic logic fits(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] lo, hi;
    begin
      hi = (DW'(1) <<< (WORD_BITS - 1)) - DW'(1);
      lo = -hi - DW'(1);
      fits = (v >= lo) && (v <= hi);
    end
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  assign prod_w = mul_a * mul_b;
  assign prod = prod_w[DW-1:0];
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {5'd0, o_st, o_apx, o_less, o_den, o_num};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_P1: begin
        if (mode == MODE_MUL) begin
          mul_a = {an[NumBits-1], an};
          mul_b = {bn[NumBits-1], bn};
        end else begin
          mul_a = {an[NumBits-1], an};
          mul_b = {2'b00, bd};
        end
      end
      S_P2: begin
        if (mode == MODE_DIV) begin
          mul_a = {2'b00, ad};
          mul_b = {bn[NumBits-1], bn};
        end else begin
          mul_a = {bn[NumBits-1], bn};
          mul_b = {2'b00, ad};
        end
      end
      S_P3: begin
        mul_a = {2'b00, ad};
        mul_b = {2'b00, bd};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dv_start <= 1'b0;
    end else begin
      dv_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode <= s_tdata[2:0];
            an <= s_tdata[34:3];
            ad <= s_tdata[65:35];
            bn <= s_tdata[97:66];
            bd <= s_tdata[128:98];
            o_num <= '0;
            o_den <= DenBits'(1);
            o_less <= 1'b0;
            o_apx <= 1'b0;
            o_st <= ST_OK;
            bad <= 1'b0;
            state <= S_P1;
          end
        end
        S_P1: begin
          if (mode > 3'(MODE_CMP)) begin
            state <= S_OUT;
          end else if (ad == '0 || bd == '0 || (mode == MODE_DIV && bn == '0)) begin
            o_st <= ST_DIV0;
            state <= S_OUT;
          end else begin
            p <= prod;
            bad <= !fits(prod);
            state <= S_P2;
          end
        end
        S_P2: begin
          q <= prod;
          if (mode != MODE_MUL && !fits(prod)) bad <= 1'b1;
          state <= S_P3;
        end
        S_P3: begin
          if (mode == MODE_MUL) begin
            rn <= p;
            rd <= prod;
          end else if (mode == MODE_DIV) begin
            rn <= p;
            rd <= q;
          end else begin
            rd <= prod;
          end
          if (mode != MODE_DIV && !fits(prod)) bad <= 1'b1;
          state <= S_SUM;
        end
        S_SUM: begin
          if (mode == MODE_ADD) rn <= p + q;
          else if (mode == MODE_SUB) rn <= p - q;
          else if (mode == MODE_CMP) rn <= q - p;
          state <= S_CHK;
        end
        S_CHK: begin
          if (bad || !fits(rn)) begin
            o_st <= ST_OVF;
            state <= S_OUT;
          end else if (mode == MODE_CMP) begin
            o_less <= (rn > 0);
            dv_a <= mag(DW'(an)) * DW'(1000);
            dv_b <= DW'(ad);
            dv_start <= 1'b1;
            state <= S_QAW;
          end else if (rn == '0) begin
            state <= S_OUT;
          end else begin
            if (rd < 0) begin
              rd <= -rd;
              rn <= -rn;
            end
            state <= S_GCD;
          end
        end
        S_GCD: begin
          nm <= mag(rn);
          gy <= DW'(rd);
          state <= S_GWAIT;
          if (rd != '0) begin
            dv_a <= mag(rn);
            dv_b <= DW'(rd);
            dv_start <= 1'b1;
          end
        end
        S_GWAIT: begin
          if (dv_done) begin
            if (dv_r == '0) begin
              g <= gy;
              state <= S_RN;
            end else begin
              gy <= dv_r;
              dv_a <= gy;
              dv_b <= dv_r;
              dv_start <= 1'b1;
            end
          end
        end
        S_RN: begin
          dv_a <= nm;
          dv_b <= g;
          dv_start <= 1'b1;
          state <= S_RNW;
        end
        S_RNW: begin
          if (dv_done) begin
            nm <= dv_q;
            dv_a <= DW'(rd);
            dv_b <= g;
            dv_start <= 1'b1;
            state <= S_RDW;
          end
        end
        S_RDW: begin
          if (dv_done) begin
            if ((rn < 0 ? nm > DW'(64'h8000_0000) : nm > DW'(64'h7FFF_FFFF))
                || dv_q > DW'(64'h7FFF_FFFF)) begin
              o_st <= ST_OVF;
            end else begin
              o_num <= rn < 0 ? NumBits'(-nm) : NumBits'(nm);
              o_den <= DenBits'(dv_q);
            end
            state <= S_OUT;
          end
        end
        S_QAW: begin
          if (dv_done) begin
            qa_neg <= an[NumBits-1];
            qa_mag <= dv_q;
            dv_a <= mag(DW'(bn)) * DW'(1000);
            dv_b <= DW'(bd);
            dv_start <= 1'b1;
            state <= S_QBW;
          end
        end
        S_QBW: begin
          if (dv_done) begin
            o_apx <= (mag((qa_neg ? -$signed(qa_mag) : $signed(qa_mag))
                      - (bn[NumBits-1] ? -$signed(dv_q) : $signed(dv_q)))
                      <= DW'(10));
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_st != ST_OK) |->
      (o_num == '0 && o_den == DenBits'(1) && !o_less && !o_apx))
    else $error("failed item carries a nonzero result");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_st == ST_OK) |-> (o_den != '0))
    else $error("zero result denominator");
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("accepting while result pending");
endmodule
`default_nettype wire

>>> tb/sv/tb_rational_arithmetic_unit.sv
// testbench for rational_arithmetic_unit: directed table then random fraction items,
// each checked against its table entry or a rational predictor; depends on rau_pkg
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int MAX_SHOWN = 10;
  localparam int STALL_LIMIT = 200000;
  localparam int N_RANDOM = 750;

  typedef struct packed {
    logic [2:0] mode;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
  } op_item_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic less;
    logic approx_equal;
    logic [1:0] status;
  } frac_res_t;

  typedef struct {
    op_item_t op;
    logic has_exp;
    frac_res_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;

  rational_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frac_res_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit rx_stall_on = 1'b1;
  int mode_count[8];
  row_t rows[$];

  function automatic logic fits32(logic signed [127:0] v);
    return v >= -(128'sd1 <<< 31) && v < (128'sd1 <<< 31);
  endfunction

  function automatic logic [127:0] gcd_mag(logic [127:0] x, logic [127:0] y);
    logic [127:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic signed [127:0] thou(logic signed [127:0] n, logic signed [127:0] d);
    logic [127:0] m;
    m = n < 0 ? -n : n;
    m = (m * 1000) / d;
    return n < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic frac_res_t predict_fraction(op_item_t op);
    frac_res_t r;
    logic signed [127:0] an, ad, bn, bd, p, q, rn, rd, da;
    logic [127:0] g, mn, md;
    logic ok;
    r = '0;
    r.res_den = 31'd1;
    an = $signed(op.a_num);
    bn = $signed(op.b_num);
    ad = {97'd0, op.a_den};
    bd = {97'd0, op.b_den};
    if (op.mode > MODE_CMP) return r;
    if (ad == 0 || bd == 0 || (op.mode == MODE_DIV && bn == 0)) begin
      r.status = ST_DIV0;
      return r;
    end
    case (op.mode)
      MODE_MUL: begin
        rn = an * bn; rd = ad * bd; ok = fits32(rn) && fits32(rd);
      end
      MODE_DIV: begin
        rn = an * bd; rd = ad * bn; ok = fits32(rn) && fits32(rd);
      end
      default: begin
        p = an * bd; q = bn * ad; rd = ad * bd;
        rn = op.mode == MODE_ADD ? p + q : (op.mode == MODE_SUB ? p - q : q - p);
        ok = fits32(p) && fits32(q) && fits32(rd) && fits32(rn);
      end
    endcase
    if (!ok) begin
      r.status = ST_OVF;
      return r;
    end
    if (op.mode == MODE_CMP) begin
      r.less = rn > 0;
      da = thou(an, ad) - thou(bn, bd);
      r.approx_equal = da >= -10 && da <= 10;
      return r;
    end
    if (rn == 0) return r;
    if (rd < 0) begin
      rd = -rd; rn = -rn;
    end
    mn = rn < 0 ? -rn : rn;
    md = rd;
    g = gcd_mag(mn, md);
    mn = mn / g;
    md = md / g;
    if ((rn < 0 ? mn > 128'h80000000 : mn > 128'h7fffffff) || md > 128'h7fffffff) begin
      r.status = ST_OVF;
      return r;
    end
    rn = rn < 0 ? -$signed(mn) : $signed(mn);
    r.res_num = rn[31:0];
    r.res_den = md[30:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 2000) - 1000;
      2: return $urandom_range(0, 131070) - 65535;
      3: return {$urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(1, 12));
      1: return 31'($urandom_range(1, 1000));
      2: return 31'($urandom_range(1, 65535));
      3: return 31'h7fffffff;
      4: return $urandom_range(0, 20) == 0 ? 31'd0 : 31'($urandom_range(1, 7));
      default: begin
        logic [30:0] d;
        d = 31'($urandom);
        return d == 0 ? 31'd1 : d;
      end
    endcase
  endfunction

  function automatic op_item_t rand_op();
    op_item_t o;
    o.mode = $urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    o.a_num = rand_num();
    o.a_den = rand_den();
    o.b_num = $urandom_range(0, 15) == 0 ? 32'd0 : rand_num();
    o.b_den = rand_den();
    return o;
  endfunction

  function automatic row_t mk(logic [2:0] m, logic [31:0] an, logic [30:0] ad,
                              logic [31:0] bn, logic [30:0] bd, logic he,
                              logic [31:0] en, logic [30:0] ed, logic [1:0] st);
    row_t w;
    w.op = '{mode: m, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    w.has_exp = he;
    w.exp = '{res_num: en, res_den: ed, less: 1'b0, approx_equal: 1'b0, status: st};
    return w;
  endfunction

  // valid stays high after a transfer until an idle gap here or the main loop drops it
  task automatic send_fraction(op_item_t op, logic random_gaps);
    if (random_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pending_results.push_back(predict_fraction(op));
    mode_count[op.mode]++;
    s_tdata <= {7'd0, op.b_den, op.b_num, op.a_den, op.a_num, op.mode};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receive side with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      rx_hold <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frac_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{res_num: m_tdata[31:0], res_den: m_tdata[62:32], less: m_tdata[63],
              approx_equal: m_tdata[64], status: m_tdata[66:65]};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: num %h/%h den %h/%h less %b/%b approx %b/%b st %0d/%0d",
                     want.res_num, got.res_num, want.res_den, got.res_den, want.less,
                     got.less, want.approx_equal, got.approx_equal, want.status, got.status);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_rational_arithmetic_unit: done, errors");
      $finish;
    end
  end

  initial begin
    op_item_t op;
    rows.push_back(mk(MODE_ADD, 32'd1, 31'd2, 32'd1, 31'd3, 1'b1, 32'd5, 31'd6, ST_OK));
    rows.push_back(mk(MODE_SUB, 32'd1, 31'd2, 32'd1, 31'd2, 1'b1, 32'd0, 31'd1, ST_OK));
    rows.push_back(mk(MODE_MUL, -32'sd2, 31'd3, 32'd3, 31'd4, 1'b1, -32'sd1, 31'd2, ST_OK));
    rows.push_back(mk(MODE_DIV, 32'd1, 31'd2, -32'sd1, 31'd4, 1'b1, -32'sd2, 31'd1, ST_OK));
    rows.push_back(mk(MODE_DIV, 32'd5, 31'd1, 32'd0, 31'd1, 1'b1, 32'd0, 31'd1, ST_DIV0));
    rows.push_back(mk(MODE_ADD, 32'd1, 31'd0, 32'd1, 31'd1, 1'b1, 32'd0, 31'd1, ST_DIV0));
    rows.push_back(mk(MODE_CMP, 32'd1, 31'd1, 32'd1, 31'd0, 1'b1, 32'd0, 31'd1, ST_DIV0));
    rows.push_back(mk(3'd5, 32'd7, 31'd1, 32'd3, 31'd1, 1'b1, 32'd0, 31'd1, ST_OK));
    rows.push_back(mk(3'd7, 32'hffffffff, 31'h7fffffff, 32'hffffffff, 31'h7fffffff,
                      1'b1, 32'd0, 31'd1, ST_OK));
    rows.push_back(mk(MODE_MUL, 32'h7fffffff, 31'd1, 32'd2, 31'd1, 1'b1, 32'd0, 31'd1, ST_OVF));
    rows.push_back(mk(MODE_ADD, 32'h7fffffff, 31'd1, 32'd1, 31'd1, 1'b1, 32'd0, 31'd1, ST_OVF));
    rows.push_back(mk(MODE_SUB, 32'h80000000, 31'd1, 32'd1, 31'd1, 1'b1, 32'd0, 31'd1, ST_OVF));
    rows.push_back(mk(MODE_MUL, 32'd1, 31'h7fffffff, 32'd1, 31'd2, 1'b1, 32'd0, 31'd1, ST_OVF));
    rows.push_back(mk(MODE_DIV, 32'd1, 31'd1, 32'h80000000, 31'd1, 1'b1, 32'd0, 31'd1, ST_OVF));
    rows.push_back(mk(MODE_MUL, 32'h80000000, 31'd1, 32'd1, 31'd1,
                      1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_MUL, 32'h80000000, 31'd1, 32'hffffffff, 31'd1,
                      1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_DIV, 32'h7fffffff, 31'd1, 32'h7fffffff, 31'h7fffffff,
                      1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_CMP, 32'd1, 31'd3, 32'd1, 31'd2, 1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_CMP, 32'd1, 31'd2, 32'd1, 31'd3, 1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_CMP, 32'd1000, 31'd1000, 32'd101, 31'd100,
                      1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_CMP, -32'sd1, 31'd1000, 32'd1, 31'd100,
                      1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_CMP, 32'd5, 31'd7, 32'd5, 31'd7, 1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_ADD, 32'h7fffffff, 31'h7fffffff, 32'h80000001, 31'h7fffffff,
                      1'b0, 32'd0, 31'd0, ST_OK));
    rows.push_back(mk(MODE_SUB, 32'd6, 31'd4, 32'd0, 31'd9, 1'b0, 32'd0, 31'd0, ST_OK));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_fraction(rows[i].op, 1'b0);
      if (rows[i].has_exp) pending_results[pending_results.size() - 1] = rows[i].exp;
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (i == N_RANDOM - 60) rx_stall_on = 1'b0;
      op = rand_op();
      send_fraction(op, i < N_RANDOM - 60);
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d results: add %0d sub %0d mul %0d div %0d cmp %0d unused %0d",
             results_seen, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             mode_count[4], mode_count[5] + mode_count[6] + mode_count[7]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_rational_arithmetic_unit: done, clean");
    end else begin
      $display("tb_rational_arithmetic_unit: done, errors");
    end
    $finish;
  end
endmodule
